FILE: hw/rtl/mec_pkg.sv
// mec_pkg: widths, reset values, register indexes and the command and status
// structs shared by the escape-count controller, datapath and register file.
// No dependencies.
`default_nettype none

package mec_pkg;

   // field widths
   localparam int COUNT_BITS     = 16;
   localparam int PIXEL_BITS     = 12;
   localparam int DIM_BITS       = 13;
   localparam int COORD_BITS     = 64;
   localparam int STEP_BITS      = 63;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 64;

   // fixed point: Q8.56 coordinates, Q16.112 exact products
   localparam int FRAC_BITS  = 56;
   localparam int WIDE_BITS  = 2 * COORD_BITS;
   localparam int HALF_BITS  = COORD_BITS / 2;
   localparam int ESC_BIT    = 2 * FRAC_BITS + 2;

   // partial product alignment
   localparam int SHIFT_BITS = 7;
   localparam logic [SHIFT_BITS-1:0] SH_0  = SHIFT_BITS'(0);
   localparam logic [SHIFT_BITS-1:0] SH_1  = SHIFT_BITS'(1);
   localparam logic [SHIFT_BITS-1:0] SH_32 = SHIFT_BITS'(HALF_BITS);
   localparam logic [SHIFT_BITS-1:0] SH_33 = SHIFT_BITS'(HALF_BITS + 1);
   localparam logic [SHIFT_BITS-1:0] SH_64 = SHIFT_BITS'(2 * HALF_BITS);
   localparam logic [SHIFT_BITS-1:0] SH_65 = SHIFT_BITS'(2 * HALF_BITS + 1);

   // sequencer step counter
   localparam int STEP_CNT_BITS = 4;

   // largest view dimension honored
   localparam logic [DIM_BITS-1:0] MAX_DIM = DIM_BITS'(4096);

   // register reset values
   localparam logic [COORD_BITS-1:0] CENTER_RESET = '0;
   localparam logic [STEP_BITS-1:0]  STEP_RESET   = STEP_BITS'(64'd72057594037927);
   localparam logic [DIM_BITS-1:0]   DIM_RESET    = DIM_BITS'(1024);
   localparam logic [COUNT_BITS-1:0] ITER_RESET   = COUNT_BITS'(256);

   // register indexes
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_CENTER_REAL  = 3'd0,
      REG_CENTER_IMAG  = 3'd1,
      REG_PIXEL_STEP   = 3'd2,
      REG_VIEW_COLS    = 3'd3,
      REG_VIEW_ROWS    = 3'd4,
      REG_MAX_ITER     = 3'd5
   } csr_reg_type;

   // multiplier operand sources, 32-bit slices
   typedef enum logic [3:0] {
      OPND_PX,
      OPND_PY,
      OPND_HW,
      OPND_HH,
      OPND_STEP_LO,
      OPND_STEP_HI,
      OPND_ZR_LO,
      OPND_ZR_HI,
      OPND_ZI_LO,
      OPND_ZI_HI
   } opnd_sel_type;

   // where a finished accumulation is copied
   typedef enum logic [1:0] {
      DEST_NONE,
      DEST_R2,
      DEST_I2
   } acc_dest_type;

   // add, subtract, or follow the sign of zr*zi
   typedef enum logic [1:0] {
      ACC_ADD,
      ACC_SUB,
      ACC_SIGN
   } acc_mode_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] center_real;
      logic [COORD_BITS-1:0] center_imag;
      logic [STEP_BITS-1:0]  pixel_step;
      logic [DIM_BITS-1:0]   view_cols;
      logic [DIM_BITS-1:0]   view_rows;
      logic [COUNT_BITS-1:0] max_iterations;
   } cfg_type;

   typedef struct packed {
      logic                  load_pixel;
      logic                  mul_en;
      opnd_sel_type          a_sel;
      opnd_sel_type          b_sel;
      logic [SHIFT_BITS-1:0] shift;
      acc_mode_type          mode;
      logic                  first;
      acc_dest_type          dest;
      logic                  load_cx;
      logic                  load_cy;
      logic                  mag;
      logic                  test;
      logic                  update;
   } cmd_type;

   typedef struct packed {
      logic esc;
   } status_type;

endpackage

`default_nettype wire

FILE: hw/rtl/mec_if.sv
// mec_if: valid/ready channel interfaces for pixel items and count items.
// Depends on mec_pkg.
`default_nettype none

interface mec_pixel_if import mec_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [PIXEL_BITS-1:0] pixel_x;
   logic [PIXEL_BITS-1:0] pixel_y;

   modport source (output valid, output pixel_x, output pixel_y, input ready);
   modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface mec_count_if import mec_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [COUNT_BITS-1:0] iteration_count;

   modport source (output valid, output iteration_count, input ready);
   modport sink   (input valid, input iteration_count, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/mec_regs.sv
// mec_regs: configuration registers written through the csr port.
// Depends on mec_pkg.
`default_nettype none

module mec_regs import mec_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata,
   output cfg_type                   cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // decode the write, unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            REG_CENTER_REAL:  cfg_in.center_real    = csr_wdata[COORD_BITS-1:0];
            REG_CENTER_IMAG:  cfg_in.center_imag    = csr_wdata[COORD_BITS-1:0];
            REG_PIXEL_STEP:   cfg_in.pixel_step     = csr_wdata[STEP_BITS-1:0];
            REG_VIEW_COLS:    cfg_in.view_cols      = csr_wdata[DIM_BITS-1:0];
            REG_VIEW_ROWS:    cfg_in.view_rows      = csr_wdata[DIM_BITS-1:0];
            REG_MAX_ITER:     cfg_in.max_iterations = csr_wdata[COUNT_BITS-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.center_real    <= CENTER_RESET;
         cfg_ff.center_imag    <= CENTER_RESET;
         cfg_ff.pixel_step     <= STEP_RESET;
         cfg_ff.view_cols      <= DIM_RESET;
         cfg_ff.view_rows      <= DIM_RESET;
         cfg_ff.max_iterations <= ITER_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/mec_dpath.sv
// mec_dpath: coordinate setup and z <- z^2 + c rounds on one shared 32x32
// multiplier feeding a 128-bit accumulator. Depends on mec_pkg.
`default_nettype none

module mec_dpath import mec_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  cfg_type               cfg,
   input  cmd_type               cmd,
   input  logic [PIXEL_BITS-1:0] pixel_x,
   input  logic [PIXEL_BITS-1:0] pixel_y,
   output status_type            status
);

   logic [PIXEL_BITS-1:0] px_ff, py_ff;
   logic [COORD_BITS-1:0] mzr_ff, mzi_ff;
   logic                  sgn_ff;
   logic [COORD_BITS-1:0] prod_ff;
   logic                  acc_valid_ff;
   logic [SHIFT_BITS-1:0] acc_shift_ff;
   logic                  acc_sub_ff;
   logic                  acc_first_ff;
   acc_dest_type          acc_dest_ff;
   logic [WIDE_BITS-1:0]  acc_ff, r2_ff, i2_ff;
   logic [COORD_BITS-1:0] cr_ff, ci_ff, zr_ff, zi_ff, diff_ff;
   logic                  esc_ff;

   logic [DIM_BITS-1:0]   w_clamp, h_clamp;
   logic [HALF_BITS-1:0]  opa, opb;
   logic [COORD_BITS-1:0] mul_res;
   logic [WIDE_BITS-1:0]  term, base, acc_in;
   logic [WIDE_BITS-1:0]  sq_sum, sq_diff;
   logic [COORD_BITS-1:0] half_step;
   logic [COORD_BITS-1:0] cx_in, cy_in;

   function automatic logic [DIM_BITS-1:0] clamp_dim(input logic [DIM_BITS-1:0] d);
      return (d > MAX_DIM) ? MAX_DIM : d;
   endfunction

   function automatic logic [HALF_BITS-1:0] pick(
      input opnd_sel_type          sel,
      input logic [PIXEL_BITS-1:0] px,
      input logic [PIXEL_BITS-1:0] py,
      input logic [DIM_BITS-1:0]   wc,
      input logic [DIM_BITS-1:0]   hc,
      input logic [STEP_BITS-1:0]  step,
      input logic [COORD_BITS-1:0] mzr,
      input logic [COORD_BITS-1:0] mzi
   );
      logic [HALF_BITS-1:0] v;
      case (sel)
         OPND_PX:      v = HALF_BITS'(px);
         OPND_PY:      v = HALF_BITS'(py);
         OPND_HW:      v = HALF_BITS'(wc[DIM_BITS-1:1]);
         OPND_HH:      v = HALF_BITS'(hc[DIM_BITS-1:1]);
         OPND_STEP_LO: v = step[HALF_BITS-1:0];
         OPND_STEP_HI: v = HALF_BITS'(step[STEP_BITS-1:HALF_BITS]);
         OPND_ZR_LO:   v = mzr[HALF_BITS-1:0];
         OPND_ZR_HI:   v = mzr[COORD_BITS-1:HALF_BITS];
         OPND_ZI_LO:   v = mzi[HALF_BITS-1:0];
         OPND_ZI_HI:   v = mzi[COORD_BITS-1:HALF_BITS];
         default:      v = '0;
      endcase
      return v;
   endfunction

   // clamped view dimensions
   assign w_clamp = clamp_dim(cfg.view_cols);
   assign h_clamp = clamp_dim(cfg.view_rows);

   // operand select and multiply
   assign opa     = pick(cmd.a_sel, px_ff, py_ff, w_clamp, h_clamp, cfg.pixel_step,
                         mzr_ff, mzi_ff);
   assign opb     = pick(cmd.b_sel, px_ff, py_ff, w_clamp, h_clamp, cfg.pixel_step,
                         mzr_ff, mzi_ff);
   assign mul_res = opa * opb;

   // align the partial product and accumulate
   assign term   = WIDE_BITS'(prod_ff) << acc_shift_ff;
   assign base   = acc_first_ff ? '0 : acc_ff;
   assign acc_in = acc_sub_ff ? (base - term) : (base + term);

   // escape test and real part difference
   assign sq_sum  = r2_ff + i2_ff;
   assign sq_diff = r2_ff - i2_ff;

   // c = center - half span + index * step, with the odd half step
   assign half_step = COORD_BITS'(cfg.pixel_step[STEP_BITS-1:1]);
   assign cx_in = cfg.center_real + acc_ff[COORD_BITS-1:0]
                  - (w_clamp[0] ? half_step : '0);
   assign cy_in = cfg.center_imag + acc_ff[COORD_BITS-1:0]
                  - (h_clamp[0] ? half_step : '0);

   // accumulator stage control
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_valid_ff <= 1'b0;
      end else begin
         acc_valid_ff <= cmd.mul_en;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (cmd.load_pixel) begin
         px_ff <= pixel_x;
         py_ff <= pixel_y;
      end
      if (cmd.mul_en) begin
         prod_ff      <= mul_res;
         acc_shift_ff <= cmd.shift;
         acc_first_ff <= cmd.first;
         acc_dest_ff  <= cmd.dest;
         acc_sub_ff   <= (cmd.mode == ACC_SIGN) ? sgn_ff : (cmd.mode == ACC_SUB);
      end
      if (acc_valid_ff) begin
         acc_ff <= acc_in;
         if (acc_dest_ff == DEST_R2) begin
            r2_ff <= acc_in;
         end
         if (acc_dest_ff == DEST_I2) begin
            i2_ff <= acc_in;
         end
      end
      if (cmd.load_cx) begin
         cr_ff <= cx_in;
         zr_ff <= cx_in;
      end
      if (cmd.load_cy) begin
         ci_ff <= cy_in;
         zi_ff <= cy_in;
      end
      // magnitudes for the unsigned partial products
      if (cmd.mag) begin
         mzr_ff <= zr_ff[COORD_BITS-1] ? (COORD_BITS'(0) - zr_ff) : zr_ff;
         mzi_ff <= zi_ff[COORD_BITS-1] ? (COORD_BITS'(0) - zi_ff) : zi_ff;
         sgn_ff <= zr_ff[COORD_BITS-1] ^ zi_ff[COORD_BITS-1];
      end
      // |z|^2 >= 4 and (zr^2 - zi^2) >> 56
      if (cmd.test) begin
         esc_ff  <= |sq_sum[WIDE_BITS-1:ESC_BIT];
         diff_ff <= sq_diff[FRAC_BITS+COORD_BITS-1:FRAC_BITS];
      end
      // next z, accumulator holds 2*zr*zi
      if (cmd.update) begin
         zr_ff <= diff_ff + cr_ff;
         zi_ff <= acc_ff[FRAC_BITS+COORD_BITS-1:FRAC_BITS] + ci_ff;
      end
   end

   assign status.esc = esc_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/mec_ctrl.sv
// mec_ctrl: sequencer for coordinate setup and escape rounds, iteration count
// and the registered count output. Depends on mec_pkg.
`default_nettype none

module mec_ctrl import mec_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [COUNT_BITS-1:0] max_iterations,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [COUNT_BITS-1:0] rsp_count,
   input  status_type            status,
   output cmd_type               cmd
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_CX,
      S_CX_WAIT,
      S_CX_LOAD,
      S_CY,
      S_CY_WAIT,
      S_CY_LOAD,
      S_MAG,
      S_SQ,
      S_WAIT,
      S_DECIDE,
      S_FINISH
   } state_type;

   localparam logic [STEP_CNT_BITS-1:0] COORD_LAST = STEP_CNT_BITS'(3);
   localparam logic [STEP_CNT_BITS-1:0] SQ_LAST    = STEP_CNT_BITS'(9);

   state_type                state_ff, state_in;
   logic [STEP_CNT_BITS-1:0] step_ff, step_in;
   logic [COUNT_BITS-1:0]    cnt_ff, cnt_in, cnt_next;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [COUNT_BITS-1:0]    rsp_count_ff, rsp_count_in;
   logic                     is_y;

   assign cnt_next = cnt_ff + COUNT_BITS'(1);
   assign is_y     = (state_ff == S_CY);

   // command decode
   always_comb begin
      cmd = '0;
      case (state_ff)
         S_IDLE: begin
            cmd.load_pixel = req_valid;
         end
         // index*step - half_dim*step, 32-bit slices of the step
         S_CX, S_CY: begin
            cmd.mul_en = 1'b1;
            case (step_ff)
               STEP_CNT_BITS'(0): begin
                  cmd.a_sel = is_y ? OPND_PY : OPND_PX;
                  cmd.b_sel = OPND_STEP_LO;
                  cmd.shift = SH_0;
                  cmd.first = 1'b1;
               end
               STEP_CNT_BITS'(1): begin
                  cmd.a_sel = is_y ? OPND_PY : OPND_PX;
                  cmd.b_sel = OPND_STEP_HI;
                  cmd.shift = SH_32;
               end
               STEP_CNT_BITS'(2): begin
                  cmd.a_sel = is_y ? OPND_HH : OPND_HW;
                  cmd.b_sel = OPND_STEP_LO;
                  cmd.shift = SH_0;
                  cmd.mode  = ACC_SUB;
               end
               default: begin
                  cmd.a_sel = is_y ? OPND_HH : OPND_HW;
                  cmd.b_sel = OPND_STEP_HI;
                  cmd.shift = SH_32;
                  cmd.mode  = ACC_SUB;
               end
            endcase
         end
         S_CX_LOAD: cmd.load_cx = 1'b1;
         S_CY_LOAD: cmd.load_cy = 1'b1;
         S_MAG:     cmd.mag     = 1'b1;
         // zr^2, zi^2, then signed 2*zr*zi
         S_SQ: begin
            cmd.mul_en = 1'b1;
            case (step_ff)
               STEP_CNT_BITS'(0): begin
                  cmd.a_sel = OPND_ZR_LO; cmd.b_sel = OPND_ZR_LO;
                  cmd.shift = SH_0;       cmd.first = 1'b1;
               end
               STEP_CNT_BITS'(1): begin
                  cmd.a_sel = OPND_ZR_LO; cmd.b_sel = OPND_ZR_HI;
                  cmd.shift = SH_33;
               end
               STEP_CNT_BITS'(2): begin
                  cmd.a_sel = OPND_ZR_HI; cmd.b_sel = OPND_ZR_HI;
                  cmd.shift = SH_64;      cmd.dest  = DEST_R2;
               end
               STEP_CNT_BITS'(3): begin
                  cmd.a_sel = OPND_ZI_LO; cmd.b_sel = OPND_ZI_LO;
                  cmd.shift = SH_0;       cmd.first = 1'b1;
               end
               STEP_CNT_BITS'(4): begin
                  cmd.a_sel = OPND_ZI_LO; cmd.b_sel = OPND_ZI_HI;
                  cmd.shift = SH_33;
               end
               STEP_CNT_BITS'(5): begin
                  cmd.a_sel = OPND_ZI_HI; cmd.b_sel = OPND_ZI_HI;
                  cmd.shift = SH_64;      cmd.dest  = DEST_I2;
               end
               STEP_CNT_BITS'(6): begin
                  cmd.a_sel = OPND_ZR_LO; cmd.b_sel = OPND_ZI_LO;
                  cmd.shift = SH_1;       cmd.first = 1'b1;
                  cmd.mode  = ACC_SIGN;
               end
               STEP_CNT_BITS'(7): begin
                  cmd.a_sel = OPND_ZR_LO; cmd.b_sel = OPND_ZI_HI;
                  cmd.shift = SH_33;      cmd.mode  = ACC_SIGN;
               end
               STEP_CNT_BITS'(8): begin
                  cmd.a_sel = OPND_ZR_HI; cmd.b_sel = OPND_ZI_LO;
                  cmd.shift = SH_33;      cmd.mode  = ACC_SIGN;
               end
               default: begin
                  cmd.a_sel = OPND_ZR_HI; cmd.b_sel = OPND_ZI_HI;
                  cmd.shift = SH_65;      cmd.mode  = ACC_SIGN;
               end
            endcase
         end
         S_WAIT:   cmd.test   = 1'b1;
         S_DECIDE: cmd.update = !status.esc;
         default:  cmd = '0;
      endcase
   end

   // next state, counters and output register
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_count_in = rsp_count_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cnt_in   = '0;
               step_in  = '0;
               state_in = S_CX;
            end
         end
         S_CX: begin
            step_in = step_ff + STEP_CNT_BITS'(1);
            if (step_ff == COORD_LAST) begin
               step_in  = '0;
               state_in = S_CX_WAIT;
            end
         end
         S_CX_WAIT: state_in = S_CX_LOAD;
         S_CX_LOAD: state_in = S_CY;
         S_CY: begin
            step_in = step_ff + STEP_CNT_BITS'(1);
            if (step_ff == COORD_LAST) begin
               step_in  = '0;
               state_in = S_CY_WAIT;
            end
         end
         S_CY_WAIT: state_in = S_CY_LOAD;
         S_CY_LOAD: begin
            // a zero limit runs no round
            state_in = (max_iterations == '0) ? S_FINISH : S_MAG;
         end
         S_MAG: begin
            step_in  = '0;
            state_in = S_SQ;
         end
         S_SQ: begin
            step_in = step_ff + STEP_CNT_BITS'(1);
            if (step_ff == SQ_LAST) begin
               step_in  = '0;
               state_in = S_WAIT;
            end
         end
         S_WAIT: state_in = S_DECIDE;
         S_DECIDE: begin
            if (status.esc) begin
               state_in = S_FINISH;
            end else begin
               cnt_in   = cnt_next;
               state_in = (cnt_next == max_iterations) ? S_FINISH : S_MAG;
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_count_in = cnt_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_count_ff <= rsp_count_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_count = rsp_count_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/mandelbrot_escape_count_unit.sv
// Escape-count unit: one pixel item in, one iteration count item out.
// From the accepting edge: coordinate setup, then for each round tested a magnitude step,
// 10 partial products on the one 32x32 multiplier, a drain step and a decide step,
// then the count is registered, which waits while an older count is unread.
// One item at a time: the unit takes no new pixel item until the count is registered.
// Synchronous reset restores register defaults and idles control.
`default_nettype none

module mandelbrot_escape_count_unit import mec_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   mec_pixel_if.sink                 req_if,
   mec_count_if.source               rsp_if,
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;

   // configuration registers
   mec_regs u_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // sequencer
   mec_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .max_iterations (cfg.max_iterations),
      .req_valid      (req_if.valid),
      .req_ready      (req_if.ready),
      .rsp_valid      (rsp_if.valid),
      .rsp_ready      (rsp_if.ready),
      .rsp_count      (rsp_if.iteration_count),
      .status         (status),
      .cmd            (cmd)
   );

   // arithmetic
   mec_dpath u_dpath (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .cmd     (cmd),
      .pixel_x (req_if.pixel_x),
      .pixel_y (req_if.pixel_y),
      .status  (status)
   );

endmodule

`default_nettype wire

FILE: hw/rtl/mec_checker.sv
// mec_checker: port-level assertions for the escape-count unit, bound to the
// top level. Depends on mec_pkg.
`default_nettype none

module mec_checker import mec_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [COUNT_BITS-1:0] rsp_count
);

   // a stalled count item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_count))
      else $error("count item changed while stalled");

   // no count item right out of reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("count item present after reset");

   // one item at a time: taking an item closes the input
   a_one_inflight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second item taken while one is in work");

   // coordinate setup runs first, so a count never follows an accept directly
   a_no_instant: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_valid && req_ready))
      else $error("count item appeared right after an accept");

endmodule

bind mandelbrot_escape_count_unit mec_checker u_mec_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_if.valid),
   .req_ready (req_if.ready),
   .rsp_valid (rsp_if.valid),
   .rsp_ready (rsp_if.ready),
   .rsp_count (rsp_if.iteration_count)
);

`default_nettype wire
